// File: design/circle_circle_intersection_core_defines.svh
// Assertion macros for the circle intersection core.
`ifndef CIRCLE_CIRCLE_INTERSECTION_CORE_DEFINES_SVH
`define CIRCLE_CIRCLE_INTERSECTION_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CCIC_ASSERT_ALWAYS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ccic: assertion failed");
// Next-cycle implication.
`define CCIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ccic: assertion failed");
`else
`define CCIC_ASSERT_ALWAYS(label, clk, rst, ante, cons)
`define CCIC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: design/ccic_pkg.sv
// Shared types and constants of the circle intersection core.
package ccic_pkg;

   // Result status codes.
   typedef enum logic [1:0] {
      STATUS_MEET  = 2'd0,
      STATUS_APART = 2'd1,
      STATUS_SAME  = 2'd2
   } status_type;

   // Lane order of the four result coordinates.
   localparam int LANE_AX = 0;
   localparam int LANE_AY = 1;
   localparam int LANE_BX = 2;
   localparam int LANE_BY = 3;
   localparam int LANES   = 4;

endpackage

// File: design/ccic_req_if.sv
// Request channel: one item holds two circles.
interface ccic_req_if #(
   parameter int COORD_BITS = 24
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] first_x;
   logic signed [COORD_BITS-1:0] first_y;
   logic        [COORD_BITS-2:0] first_radius;
   logic signed [COORD_BITS-1:0] second_x;
   logic signed [COORD_BITS-1:0] second_y;
   logic        [COORD_BITS-2:0] second_radius;

   modport source (
      output valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
      input  ready
   );
   modport sink (
      input  valid, first_x, first_y, first_radius, second_x, second_y, second_radius,
      output ready
   );
endinterface

// File: design/ccic_rsp_if.sv
// Response channel: one item holds both intersection points and a status.
interface ccic_rsp_if #(
   parameter int COORD_BITS = 24
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_a_x;
   logic signed [COORD_BITS-1:0] point_a_y;
   logic signed [COORD_BITS-1:0] point_b_x;
   logic signed [COORD_BITS-1:0] point_b_y;
   logic        [1:0]            status;

   modport source (
      output valid, point_a_x, point_a_y, point_b_x, point_b_y, status,
      input  ready
   );
   modport sink (
      input  valid, point_a_x, point_a_y, point_b_x, point_b_y, status,
      output ready
   );
endinterface

// File: design/circle_circle_intersection_core.sv
// Circle-circle intersection core: a fully pipelined fixed-point datapath.
// Accepts one item per clock while rsp is not stalled and returns one result per item, in order.
// Stages from acceptance to rsp valid:
// seven setup/multiply stages, a 2*COORD_BITS+1 stage bit-serial square root,
// five stages forming the numerators, their magnitudes and the rounding bias,
// and a COORD_BITS stage restoring divider (four lanes side by side) followed
// by the saturating output register.
// The whole pipeline advances together and freezes while a result waits at rsp.
// Results are rounded from the raw values; the fraction point position does not
// enter the arithmetic. Points are zero unless status is STATUS_MEET.
`include "circle_circle_intersection_core_defines.svh"

module circle_circle_intersection_core #(
   parameter int COORD_BITS = 24
) (
   input  logic      clock,
   input  logic      reset,
   ccic_req_if.sink  req_ch,
   ccic_rsp_if.source rsp_ch
);

   localparam int C    = COORD_BITS;
   localparam int H    = C + 1;          // split point of wide multiplies
   localparam int DW   = C + 1;          // coordinate sums and differences
   localparam int RW   = C - 1;          // radius
   localparam int SW   = C;              // radius sum
   localparam int D2W  = 2 * C + 2;      // squared distance
   localparam int KW   = 2 * C - 1;      // r0^2 - r1^2, signed
   localparam int F1W  = 2 * C;
   localparam int F2W  = 2 * C + 2;
   localparam int PW   = F1W + F2W;      // radicand
   localparam int RTW  = 2 * C + 1;      // square root
   localparam int PPW  = 2 * C + 4;      // partial products
   localparam int NW   = 3 * C + 6;      // numerators and divider remainder
   localparam int DVW  = D2W + 1;        // divisor 2*d2
   localparam int LN   = ccic_pkg::LANES;

   // Pipeline positions
   localparam int SQ0  = 6;
   localparam int T1   = SQ0 + RTW + 1;
   localparam int DV0  = T1 + 4;
   localparam int OUT  = DV0 + C + 1;
   localparam int NST  = OUT + 1;

   typedef struct {
      logic signed [DW-1:0] dx, dy, apc, bpd, amc, bmd;
      logic [RW-1:0]        dr, r0, r1;
      logic [SW-1:0]        rs;
   } s1_type;

   typedef struct {
      logic [2*C-1:0]       dxx, dyy, s2;
      logic [2*RW-1:0]      m2, r0sq, r1sq;
      logic signed [DW-1:0] dx, dy, apc, bpd, amc, bmd;
   } s2_type;

   typedef struct {
      logic [D2W-1:0]       d2;
      logic signed [KW-1:0] k;
      logic [2*RW-1:0]      m2;
      logic [2*C-1:0]       s2;
      logic signed [DW-1:0] dx, dy, apc, bpd, amc, bmd;
   } s3_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [F1W-1:0]        f1;
      logic [F2W-1:0]        f2;
      logic signed [PPW-1:0] pal, pah, pbl, pbh, pxl, pxh, pyl, pyh;
      logic [D2W-1:0]        d2;
      logic signed [DW-1:0]  amc, bmd;
   } s4_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [2*H-1:0]        pll, plh, phl, phh;
      logic signed [NW-1:0]  bxa, bxk, bya, byk;
      logic [D2W-1:0]        d2;
      logic signed [DW-1:0]  amc, bmd;
   } s5_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [PW-1:0]         outer;
      logic [2*H:0]          mid;
      logic signed [NW-1:0]  basex, basey;
      logic [D2W-1:0]        d2;
      logic signed [DW-1:0]  amc, bmd;
   } s6_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic signed [NW-1:0]  basex, basey;
      logic [D2W-1:0]        d2;
      logic signed [DW-1:0]  amc, bmd;
      logic [PW-1:0]         rem;
      logic [RTW-1:0]        root;
   } sq_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic signed [PPW-1:0] ptxl, ptxh, ptyl, ptyh;
      logic signed [NW-1:0]  basex, basey;
      logic [D2W-1:0]        d2;
   } t1_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic signed [NW-1:0]  tx, ty, basex, basey;
      logic [D2W-1:0]        d2;
   } t2_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [LN-1:0][NW-1:0] num;
      logic [D2W-1:0]        d2;
   } t3_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [LN-1:0]         neg;
      logic [LN-1:0][NW-1:0] mag;
      logic [D2W-1:0]        d2;
   } t4_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [DVW-1:0]        d;
      logic [LN-1:0]         ovf, neg;
      logic [LN-1:0][NW-1:0] rem;
      logic [LN-1:0][C-1:0]  q;
   } dv_type;

   typedef struct {
      ccic_pkg::status_type  status;
      logic [LN-1:0][C-1:0]  pt;
   } out_type;

   logic           adv;
   logic [NST-1:0] vld_ff;
   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   s3_type  s3_in, s3_ff;
   s4_type  s4_in, s4_ff;
   s5_type  s5_in, s5_ff;
   s6_type  s6_in, s6_ff;
   sq_type  sq_in [0:RTW];
   sq_type  sq_ff [0:RTW];
   t1_type  t1_in, t1_ff;
   t2_type  t2_in, t2_ff;
   t3_type  t3_in, t3_ff;
   t4_type  t4_in, t4_ff;
   dv_type  dv_in [0:C];
   dv_type  dv_ff [0:C];
   out_type out_in, out_ff;

   // Whole pipeline moves when the output slot is free or being taken
   assign adv          = !vld_ff[OUT] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_ch.valid};
      end
   end

   // Stage 1: differences, sums, radius sum and difference
   always_comb begin
      logic signed [DW-1:0] ax, ay, cx, cy;
      ax = DW'(req_ch.first_x);
      ay = DW'(req_ch.first_y);
      cx = DW'(req_ch.second_x);
      cy = DW'(req_ch.second_y);
      s1_in.dx  = cx - ax;
      s1_in.dy  = cy - ay;
      s1_in.apc = ax + cx;
      s1_in.bpd = ay + cy;
      s1_in.amc = ax - cx;
      s1_in.bmd = ay - cy;
      s1_in.r0  = req_ch.first_radius;
      s1_in.r1  = req_ch.second_radius;
      s1_in.dr  = (req_ch.first_radius >= req_ch.second_radius) ?
                  req_ch.first_radius - req_ch.second_radius :
                  req_ch.second_radius - req_ch.first_radius;
      s1_in.rs  = SW'(req_ch.first_radius) + SW'(req_ch.second_radius);
   end

   // Stage 2: squares
   always_comb begin
      logic signed [2*DW-1:0] dxx_full, dyy_full;
      dxx_full   = s1_ff.dx * s1_ff.dx;
      dyy_full   = s1_ff.dy * s1_ff.dy;
      s2_in.dxx  = dxx_full[2*C-1:0];
      s2_in.dyy  = dyy_full[2*C-1:0];
      s2_in.m2   = s1_ff.dr * s1_ff.dr;
      s2_in.s2   = s1_ff.rs * s1_ff.rs;
      s2_in.r0sq = s1_ff.r0 * s1_ff.r0;
      s2_in.r1sq = s1_ff.r1 * s1_ff.r1;
      s2_in.dx   = s1_ff.dx;
      s2_in.dy   = s1_ff.dy;
      s2_in.apc  = s1_ff.apc;
      s2_in.bpd  = s1_ff.bpd;
      s2_in.amc  = s1_ff.amc;
      s2_in.bmd  = s1_ff.bmd;
   end

   // Stage 3: squared distance and radius-square difference
   always_comb begin
      s3_in.d2  = D2W'(s2_ff.dxx) + D2W'(s2_ff.dyy);
      s3_in.k   = $signed({1'b0, s2_ff.r0sq}) - $signed({1'b0, s2_ff.r1sq});
      s3_in.m2  = s2_ff.m2;
      s3_in.s2  = s2_ff.s2;
      s3_in.dx  = s2_ff.dx;
      s3_in.dy  = s2_ff.dy;
      s3_in.apc = s2_ff.apc;
      s3_in.bpd = s2_ff.bpd;
      s3_in.amc = s2_ff.amc;
      s3_in.bmd = s2_ff.bmd;
   end

   // Stage 4: classify, radicand factors, base partial products
   always_comb begin
      logic [H-1:0]         d2l, kl;
      logic [D2W-H-1:0]     d2h;
      logic signed [KW-H-1:0] kh;
      logic                 meet;
      d2l  = s3_ff.d2[H-1:0];
      d2h  = s3_ff.d2[D2W-1:H];
      kl   = s3_ff.k[H-1:0];
      kh   = s3_ff.k[KW-1:H];
      meet = (D2W'(s3_ff.m2) <= s3_ff.d2) && (s3_ff.d2 <= D2W'(s3_ff.s2));
      if (s3_ff.d2 == '0) begin
         s4_in.status = ccic_pkg::STATUS_SAME;
      end else if (meet) begin
         s4_in.status = ccic_pkg::STATUS_MEET;
      end else begin
         s4_in.status = ccic_pkg::STATUS_APART;
      end
      s4_in.f1  = meet ? F1W'(D2W'(s3_ff.s2) - s3_ff.d2) : '0;
      s4_in.f2  = meet ? s3_ff.d2 - D2W'(s3_ff.m2) : '0;
      s4_in.pal = s3_ff.apc * $signed({1'b0, d2l});
      s4_in.pah = s3_ff.apc * $signed({1'b0, d2h});
      s4_in.pbl = s3_ff.bpd * $signed({1'b0, d2l});
      s4_in.pbh = s3_ff.bpd * $signed({1'b0, d2h});
      s4_in.pxl = s3_ff.dx * $signed({1'b0, kl});
      s4_in.pxh = s3_ff.dx * kh;
      s4_in.pyl = s3_ff.dy * $signed({1'b0, kl});
      s4_in.pyh = s3_ff.dy * kh;
      s4_in.d2  = s3_ff.d2;
      s4_in.amc = s3_ff.amc;
      s4_in.bmd = s3_ff.bmd;
   end

   // Stage 5: radicand partial products, merge base halves
   always_comb begin
      logic [H-1:0]       f1l, f2l;
      logic [F1W-H-1:0]   f1h;
      logic [F2W-H-1:0]   f2h;
      f1l = s4_ff.f1[H-1:0];
      f1h = s4_ff.f1[F1W-1:H];
      f2l = s4_ff.f2[H-1:0];
      f2h = s4_ff.f2[F2W-1:H];
      s5_in.status = s4_ff.status;
      s5_in.pll = f1l * f2l;
      s5_in.plh = f1l * f2h;
      s5_in.phl = f1h * f2l;
      s5_in.phh = f1h * f2h;
      s5_in.bxa = (NW'(s4_ff.pah) <<< H) + NW'(s4_ff.pal);
      s5_in.bxk = (NW'(s4_ff.pxh) <<< H) + NW'(s4_ff.pxl);
      s5_in.bya = (NW'(s4_ff.pbh) <<< H) + NW'(s4_ff.pbl);
      s5_in.byk = (NW'(s4_ff.pyh) <<< H) + NW'(s4_ff.pyl);
      s5_in.d2  = s4_ff.d2;
      s5_in.amc = s4_ff.amc;
      s5_in.bmd = s4_ff.bmd;
   end

   // Stage 6: outer and middle radicand terms, base numerators
   always_comb begin
      s6_in.status = s5_ff.status;
      s6_in.outer  = {s5_ff.phh[PW-2*H-1:0], s5_ff.pll};
      s6_in.mid    = (2*H+1)'(s5_ff.plh) + (2*H+1)'(s5_ff.phl);
      s6_in.basex  = s5_ff.bxa + s5_ff.bxk;
      s6_in.basey  = s5_ff.bya + s5_ff.byk;
      s6_in.d2     = s5_ff.d2;
      s6_in.amc    = s5_ff.amc;
      s6_in.bmd    = s5_ff.bmd;
   end

   // Stage 7: full radicand, seed the square root
   always_comb begin
      sq_in[0].status = s6_ff.status;
      sq_in[0].basex  = s6_ff.basex;
      sq_in[0].basey  = s6_ff.basey;
      sq_in[0].d2     = s6_ff.d2;
      sq_in[0].amc    = s6_ff.amc;
      sq_in[0].bmd    = s6_ff.bmd;
      sq_in[0].rem    = s6_ff.outer + (PW'(s6_ff.mid) << H);
      sq_in[0].root   = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         s5_ff    <= s5_in;
         s6_ff    <= s6_in;
         sq_ff[0] <= sq_in[0];
      end
   end

   // Square root: one result bit per stage, remainder kept as P - root^2
   for (genvar j = 0; j < RTW; j++) begin : g_sqrt
      localparam int BIT = RTW - 1 - j;
      logic [PW-1:0] trial;
      always_comb begin
         trial = (PW'(sq_ff[j].root) << (BIT + 1)) | (PW'(1) << (2 * BIT));
         sq_in[j+1] = sq_ff[j];
         if (sq_ff[j].rem >= trial) begin
            sq_in[j+1].rem  = sq_ff[j].rem - trial;
            sq_in[j+1].root = sq_ff[j].root | (RTW'(1) << BIT);
         end
      end
      always_ff @(posedge clock) begin
         if (adv) sq_ff[j+1] <= sq_in[j+1];
      end
   end

   // Offset partial products from the root
   always_comb begin
      logic [H-1:0]     sql;
      logic [RTW-H-1:0] sqh;
      sql = sq_ff[RTW].root[H-1:0];
      sqh = sq_ff[RTW].root[RTW-1:H];
      t1_in.status = sq_ff[RTW].status;
      t1_in.ptxl   = sq_ff[RTW].bmd * $signed({1'b0, sql});
      t1_in.ptxh   = sq_ff[RTW].bmd * $signed({1'b0, sqh});
      t1_in.ptyl   = sq_ff[RTW].amc * $signed({1'b0, sql});
      t1_in.ptyh   = sq_ff[RTW].amc * $signed({1'b0, sqh});
      t1_in.basex  = sq_ff[RTW].basex;
      t1_in.basey  = sq_ff[RTW].basey;
      t1_in.d2     = sq_ff[RTW].d2;
   end

   always_comb begin
      t2_in.status = t1_ff.status;
      t2_in.tx     = (NW'(t1_ff.ptxh) <<< H) + NW'(t1_ff.ptxl);
      t2_in.ty     = (NW'(t1_ff.ptyh) <<< H) + NW'(t1_ff.ptyl);
      t2_in.basex  = t1_ff.basex;
      t2_in.basey  = t1_ff.basey;
      t2_in.d2     = t1_ff.d2;
   end

   // Numerators of both roots
   always_comb begin
      t3_in.status = t2_ff.status;
      t3_in.num[ccic_pkg::LANE_AX] = t2_ff.basex + t2_ff.tx;
      t3_in.num[ccic_pkg::LANE_AY] = t2_ff.basey + t2_ff.ty;
      t3_in.num[ccic_pkg::LANE_BX] = t2_ff.basex - t2_ff.tx;
      t3_in.num[ccic_pkg::LANE_BY] = t2_ff.basey - t2_ff.ty;
      t3_in.d2     = t2_ff.d2;
   end

   // Sign and magnitude
   always_comb begin
      t4_in.status = t3_ff.status;
      t4_in.d2     = t3_ff.d2;
      for (int l = 0; l < LN; l++) begin
         t4_in.neg[l] = t3_ff.num[l][NW-1];
         t4_in.mag[l] = t3_ff.num[l][NW-1] ? -t3_ff.num[l] : t3_ff.num[l];
      end
   end

   // Rounding bias and divisor
   always_comb begin
      dv_in[0].status = t4_ff.status;
      dv_in[0].d      = {t4_ff.d2, 1'b0};
      dv_in[0].ovf    = '0;
      dv_in[0].neg    = t4_ff.neg;
      dv_in[0].q      = '0;
      for (int l = 0; l < LN; l++) begin
         dv_in[0].rem[l] = t4_ff.mag[l] + NW'(t4_ff.d2);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         t4_ff    <= t4_in;
         dv_ff[0] <= dv_in[0];
      end
   end

   // Restoring divider: one quotient bit per stage, four lanes
   for (genvar j = 0; j < C; j++) begin : g_div
      localparam int BIT = C - 1 - j;
      logic [NW-1:0] trial, top_trial;
      always_comb begin
         trial     = NW'(dv_ff[j].d) << BIT;
         top_trial = NW'(dv_ff[j].d) << C;
         dv_in[j+1] = dv_ff[j];
         for (int l = 0; l < LN; l++) begin
            if (j == 0) begin
               dv_in[j+1].ovf[l] = dv_ff[j].rem[l] >= top_trial;
            end
            if (dv_ff[j].rem[l] >= trial) begin
               dv_in[j+1].rem[l]    = dv_ff[j].rem[l] - trial;
               dv_in[j+1].q[l][BIT] = 1'b1;
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) dv_ff[j+1] <= dv_in[j+1];
      end
   end

   // Saturate, restore sign, blank points unless the circles meet
   always_comb begin
      logic [C-1:0] lim, qs;
      out_in.status = dv_ff[C].status;
      for (int l = 0; l < LN; l++) begin
         lim = dv_ff[C].neg[l] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
         qs  = (dv_ff[C].ovf[l] || dv_ff[C].q[l] > lim) ? lim : dv_ff[C].q[l];
         out_in.pt[l] = dv_ff[C].neg[l] ? -qs : qs;
         if (dv_ff[C].status != ccic_pkg::STATUS_MEET) out_in.pt[l] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) out_ff <= out_in;
   end

   assign rsp_ch.valid     = vld_ff[OUT];
   assign rsp_ch.point_a_x = out_ff.pt[ccic_pkg::LANE_AX];
   assign rsp_ch.point_a_y = out_ff.pt[ccic_pkg::LANE_AY];
   assign rsp_ch.point_b_x = out_ff.pt[ccic_pkg::LANE_BX];
   assign rsp_ch.point_b_y = out_ff.pt[ccic_pkg::LANE_BY];
   assign rsp_ch.status    = out_ff.status;

   // Checks
   `CCIC_ASSERT_ALWAYS(a_blank_points, clock, reset, vld_ff[OUT] && out_ff.status != ccic_pkg::STATUS_MEET, out_ff.pt == '0)
   `CCIC_ASSERT_ALWAYS(a_stall_blocks_req, clock, reset, vld_ff[OUT] && !rsp_ch.ready, !req_ch.ready)
   `CCIC_ASSERT_ALWAYS(a_root_tight, clock, reset, vld_ff[SQ0+RTW], sq_ff[RTW].rem <= (PW'(sq_ff[RTW].root) << 1))
   `CCIC_ASSERT_NEXT(a_stall_freeze, clock, reset, !adv, $stable(vld_ff))

endmodule
